// ===== design/dalseq_pkg.sv =====
// ----------------------------------------------------------------------------
// dalseq_pkg
// Shared types and constants for the door-open alarm sequencer: mode codes,
// register indexes and reset values, and the config and result bundles.
// ----------------------------------------------------------------------------
package dalseq_pkg;

  // Sequencer modes; the unused code behaves as closed
  typedef enum logic [1:0] {
    MODE_CLOSED  = 2'd0,
    MODE_OPEN    = 2'd1,
    MODE_CONFIRM = 2'd2
  } mode_t;

  // Configuration port geometry
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 20;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_LED_DELAY       = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BUZZER_DELAY    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLINK_PERIOD    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEARTBEAT_PER   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLOSE_CONFIRM   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CONFIRM_POLL    = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TELEMETRY_PER   = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OPEN_LEVEL      = 3'd7;

  // Register reset values
  localparam logic [19:0] RST_LED_DELAY     = 20'd20000;
  localparam logic [19:0] RST_BUZZER_DELAY  = 20'd30000;
  localparam logic [11:0] RST_BLINK_PERIOD  = 12'd250;
  localparam logic [19:0] RST_HEARTBEAT_PER = 20'd5000;
  localparam logic [15:0] RST_CLOSE_CONFIRM = 16'd3000;
  localparam logic [11:0] RST_CONFIRM_POLL  = 12'd100;
  localparam logic [19:0] RST_TELEMETRY_PER = 20'd60000;
  localparam logic        RST_OPEN_LEVEL    = 1'b1;

  // Time conversion and output limits
  localparam int          MS_PER_SEC    = 1000;
  localparam int          SECS_OUT_BITS = 23;
  localparam logic [15:0] CONFIRM_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [19:0] led_delay_ms;
    logic [19:0] buzzer_delay_ms;
    logic [11:0] blink_period_ms;
    logic [19:0] heartbeat_period_ms;
    logic [15:0] close_confirm_ms;
    logic [11:0] confirm_poll_ms;
    logic [19:0] telemetry_period_ms;
    logic        open_level;
  } cfg_t;

  typedef struct packed {
    logic                     red_on;
    logic                     green_on;
    logic                     buzzer_on;
    logic                     opened_flag;
    logic                     closed_flag;
    logic                     escalate_flag;
    logic                     heartbeat_flag;
    logic                     telemetry_flag;
    logic [SECS_OUT_BITS-1:0] open_seconds;
  } result_t;

endpackage

// ===== design/dalseq_cfg.sv =====
// ----------------------------------------------------------------------------
// dalseq_cfg
// Configuration register file: eight registers written by index, no read-back.
// ----------------------------------------------------------------------------
module dalseq_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [dalseq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [dalseq_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output dalseq_pkg::cfg_t                     cfg
);

  dalseq_pkg::cfg_t regs;

  // Load reset values, then take writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.led_delay_ms        <= dalseq_pkg::RST_LED_DELAY;
      regs.buzzer_delay_ms     <= dalseq_pkg::RST_BUZZER_DELAY;
      regs.blink_period_ms     <= dalseq_pkg::RST_BLINK_PERIOD;
      regs.heartbeat_period_ms <= dalseq_pkg::RST_HEARTBEAT_PER;
      regs.close_confirm_ms    <= dalseq_pkg::RST_CLOSE_CONFIRM;
      regs.confirm_poll_ms     <= dalseq_pkg::RST_CONFIRM_POLL;
      regs.telemetry_period_ms <= dalseq_pkg::RST_TELEMETRY_PER;
      regs.open_level          <= dalseq_pkg::RST_OPEN_LEVEL;
    end else if (cfg_write) begin
      case (cfg_index)
        dalseq_pkg::REG_LED_DELAY:     regs.led_delay_ms        <= cfg_data[19:0];
        dalseq_pkg::REG_BUZZER_DELAY:  regs.buzzer_delay_ms     <= cfg_data[19:0];
        dalseq_pkg::REG_BLINK_PERIOD:  regs.blink_period_ms     <= cfg_data[11:0];
        dalseq_pkg::REG_HEARTBEAT_PER: regs.heartbeat_period_ms <= cfg_data[19:0];
        dalseq_pkg::REG_CLOSE_CONFIRM: regs.close_confirm_ms    <= cfg_data[15:0];
        dalseq_pkg::REG_CONFIRM_POLL:  regs.confirm_poll_ms     <= cfg_data[11:0];
        dalseq_pkg::REG_TELEMETRY_PER: regs.telemetry_period_ms <= cfg_data[19:0];
        dalseq_pkg::REG_OPEN_LEVEL:    regs.open_level          <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== design/dalseq_core.sv =====
// ----------------------------------------------------------------------------
// dalseq_core
// Sequencer state and its one-tick update. The result for the sample at the
// input is formed combinationally; state advances when step is high.
// Open time is tracked both as milliseconds and as seconds plus a remainder,
// so the seconds report needs no divider.
// ----------------------------------------------------------------------------
module dalseq_core #(
  parameter int OPEN_TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                door,
  input  dalseq_pkg::cfg_t    cfg,
  output dalseq_pkg::result_t result
);

  localparam int OTB       = OPEN_TIME_BITS;
  localparam int SECS_BITS = OTB - 9;
  localparam int CMP_BITS  = (OTB > 20) ? OTB : 20;
  localparam int WIDE_SECS = (SECS_BITS > dalseq_pkg::SECS_OUT_BITS) ?
                             SECS_BITS : dalseq_pkg::SECS_OUT_BITS;
  localparam logic [OTB-1:0]       OT_MAX   = {OTB{1'b1}};
  localparam logic [SECS_BITS-1:0] SAT_SECS =
    SECS_BITS'(((64'd1 << OTB) - 64'd1) / dalseq_pkg::MS_PER_SEC);
  localparam logic [12:0] MS_SEC_13 = 13'(dalseq_pkg::MS_PER_SEC);

  // State registers
  dalseq_pkg::mode_t    mode;
  logic [11:0]          pass_timer;
  logic [OTB-1:0]       open_time;
  logic [SECS_BITS-1:0] sec_cnt;
  logic [9:0]           sec_rem;
  logic [19:0]          heartbeat_timer;
  logic [19:0]          telemetry_timer;
  logic                 red_phase;
  logic                 escalated;
  logic [15:0]          confirm_elapsed;
  logic [11:0]          poll_timer;
  logic [2:0]           drive_bits;

  dalseq_pkg::mode_t    mode_next;
  logic [11:0]          pass_timer_next;
  logic [OTB-1:0]       open_time_next;
  logic [SECS_BITS-1:0] sec_cnt_next;
  logic [9:0]           sec_rem_next;
  logic [19:0]          heartbeat_timer_next;
  logic [19:0]          telemetry_timer_next;
  logic                 red_phase_next;
  logic                 escalated_next;
  logic [15:0]          confirm_elapsed_next;
  logic [11:0]          poll_timer_next;
  logic [2:0]           drive_bits_next;

  // Events of this tick
  logic        is_open;
  logic        mode_is_open;
  logic [11:0] blink_eff;
  logic [11:0] poll_eff;
  logic [16:0] conf_sum;
  logic [15:0] conf_sat;
  logic        poll_dec;
  logic        poll_due;
  logic        reopen;
  logic        repoll;
  logic        confirm_evt;
  logic        pass_dec;
  logic        pass_due;
  logic        new_open;
  logic        close_seen;
  logic        enter_conf;
  logic        fin;
  logic        fin_open;

  // Opening-adjusted values seen by the pass
  logic [OTB-1:0] ot_cur;
  logic           red_cur;
  logic           esc_cur;
  logic [19:0]    hb_cur;
  logic           led_go;
  logic           buz_go;
  logic [2:0]     drive_pass;
  logic [OTB:0]   ot_sum;
  logic           ot_sat;
  logic [20:0]    hb_sum;
  logic           hb_fire;
  logic [20:0]    tel_sum;
  logic           tel_fire;
  logic [12:0]    rem_acc;
  logic [2:0]     sec_carry;
  logic [WIDE_SECS-1:0] secs_wide;

  // Decode what this tick does
  always_comb begin
    is_open      = (door == cfg.open_level);
    mode_is_open = (mode == dalseq_pkg::MODE_OPEN);
    blink_eff    = (cfg.blink_period_ms == 12'd0) ? 12'd1 : cfg.blink_period_ms;
    poll_eff     = (cfg.confirm_poll_ms == 12'd0) ? 12'd1 : cfg.confirm_poll_ms;
    conf_sum     = 17'(confirm_elapsed) + 17'(poll_eff);
    conf_sat     = conf_sum[16] ? dalseq_pkg::CONFIRM_MAX : conf_sum[15:0];

    poll_dec    = 1'b0;
    poll_due    = 1'b0;
    reopen      = 1'b0;
    repoll      = 1'b0;
    confirm_evt = 1'b0;
    pass_dec    = 1'b0;
    pass_due    = 1'b0;
    new_open    = 1'b0;
    close_seen  = 1'b0;
    enter_conf  = 1'b0;

    case (mode)
      dalseq_pkg::MODE_CONFIRM: begin
        if (poll_timer != 12'd0) begin
          poll_dec = 1'b1;
        end else begin
          poll_due = 1'b1;
          if (is_open) begin
            reopen = 1'b1;
          end else if (conf_sat < cfg.close_confirm_ms) begin
            repoll = 1'b1;
          end else begin
            confirm_evt = 1'b1;
          end
        end
      end
      default: begin
        if (pass_timer != 12'd0) begin
          pass_dec = 1'b1;
        end else begin
          pass_due = 1'b1;
          if (is_open && !mode_is_open) begin
            new_open = 1'b1;
          end else if (!is_open && mode_is_open) begin
            close_seen = 1'b1;
            if (cfg.close_confirm_ms == 16'd0) begin
              confirm_evt = 1'b1;
            end else begin
              enter_conf = 1'b1;
            end
          end
        end
      end
    endcase

    fin      = reopen || confirm_evt || (pass_due && !enter_conf);
    fin_open = reopen || new_open || (pass_due && is_open && mode_is_open);
  end

  // Work out the open-mode pass arithmetic
  always_comb begin
    ot_cur  = new_open ? '0 : open_time;
    red_cur = new_open ? 1'b1 : red_phase;
    esc_cur = new_open ? 1'b0 : escalated;
    hb_cur  = new_open ? 20'd0 : heartbeat_timer;

    led_go = CMP_BITS'(ot_cur) >= CMP_BITS'(cfg.led_delay_ms);
    buz_go = CMP_BITS'(ot_cur) >= CMP_BITS'(cfg.buzzer_delay_ms);
    drive_pass = 3'b000;
    if (led_go) begin
      drive_pass[0] = red_cur;
      drive_pass[1] = !red_cur;
    end
    drive_pass[2] = buz_go && red_cur;

    ot_sum = (OTB+1)'(ot_cur) + (OTB+1)'(blink_eff);
    ot_sat = ot_sum[OTB];

    hb_sum  = 21'(hb_cur) + 21'(blink_eff);
    hb_fire = hb_sum >= 21'(cfg.heartbeat_period_ms);

    tel_sum  = 21'(telemetry_timer) + 21'(blink_eff);
    tel_fire = tel_sum >= 21'(cfg.telemetry_period_ms);

    // Fold the added milliseconds into seconds, at most five carries
    rem_acc   = (new_open ? 13'd0 : 13'(sec_rem)) + 13'(blink_eff);
    sec_carry = 3'd0;
    for (int i = 0; i < 5; i++) begin
      if (rem_acc >= MS_SEC_13) begin
        rem_acc   = rem_acc - MS_SEC_13;
        sec_carry = sec_carry + 3'd1;
      end
    end
  end

  // Next state
  always_comb begin
    mode_next            = mode;
    pass_timer_next      = pass_timer;
    open_time_next       = open_time;
    sec_cnt_next         = sec_cnt;
    sec_rem_next         = sec_rem;
    heartbeat_timer_next = heartbeat_timer;
    telemetry_timer_next = telemetry_timer;
    red_phase_next       = red_phase;
    escalated_next       = escalated;
    confirm_elapsed_next = confirm_elapsed;
    poll_timer_next      = poll_timer;
    drive_bits_next      = drive_bits;

    // mode changes
    if (new_open || reopen) begin
      mode_next = dalseq_pkg::MODE_OPEN;
    end else if (confirm_evt) begin
      mode_next = dalseq_pkg::MODE_CLOSED;
    end else if (enter_conf) begin
      mode_next = dalseq_pkg::MODE_CONFIRM;
    end

    // poll and confirm timers
    if (poll_dec) begin
      poll_timer_next = poll_timer - 12'd1;
    end else if (repoll || enter_conf) begin
      poll_timer_next = poll_eff - 12'd1;
    end
    if (close_seen) begin
      confirm_elapsed_next = 16'd0;
    end else if (poll_due) begin
      confirm_elapsed_next = conf_sat;
    end

    // pass timer
    if (pass_dec) begin
      pass_timer_next = pass_timer - 12'd1;
    end else if (fin) begin
      pass_timer_next = blink_eff - 12'd1;
    end

    // drives mute on a close, reload on an open pass
    if (close_seen) begin
      drive_bits_next = 3'b000;
    end
    if (fin_open) begin
      drive_bits_next      = drive_pass;
      escalated_next       = esc_cur || buz_go;
      red_phase_next       = !red_cur;
      heartbeat_timer_next = hb_fire ? 20'd0 : hb_sum[19:0];
      if (ot_sat) begin
        open_time_next = OT_MAX;
        sec_cnt_next   = SAT_SECS;
        sec_rem_next   = sec_rem;
      end else begin
        open_time_next = ot_sum[OTB-1:0];
        sec_cnt_next   = (new_open ? '0 : sec_cnt) + SECS_BITS'(sec_carry);
        sec_rem_next   = rem_acc[9:0];
      end
    end

    // telemetry runs on every completed pass
    if (fin) begin
      telemetry_timer_next = tel_fire ? 20'd0 : tel_sum[19:0];
    end
  end

  // Result of this tick
  always_comb begin
    secs_wide             = WIDE_SECS'(sec_cnt);
    result.red_on         = drive_bits_next[0];
    result.green_on       = drive_bits_next[1];
    result.buzzer_on      = drive_bits_next[2];
    result.opened_flag    = new_open;
    result.closed_flag    = confirm_evt;
    result.escalate_flag  = fin_open && buz_go && !esc_cur;
    result.heartbeat_flag = fin_open && hb_fire;
    result.telemetry_flag = fin && tel_fire;
    if (!confirm_evt) begin
      result.open_seconds = '0;
    end else if (secs_wide > WIDE_SECS'({dalseq_pkg::SECS_OUT_BITS{1'b1}})) begin
      result.open_seconds = {dalseq_pkg::SECS_OUT_BITS{1'b1}};
    end else begin
      result.open_seconds = secs_wide[dalseq_pkg::SECS_OUT_BITS-1:0];
    end
  end

  // Advance state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= dalseq_pkg::MODE_CLOSED;
      pass_timer      <= 12'd0;
      open_time       <= '0;
      sec_cnt         <= '0;
      sec_rem         <= 10'd0;
      heartbeat_timer <= 20'd0;
      telemetry_timer <= 20'd0;
      red_phase       <= 1'b1;
      escalated       <= 1'b0;
      confirm_elapsed <= 16'd0;
      poll_timer      <= 12'd0;
      drive_bits      <= 3'b000;
    end else if (step) begin
      mode            <= mode_next;
      pass_timer      <= pass_timer_next;
      open_time       <= open_time_next;
      sec_cnt         <= sec_cnt_next;
      sec_rem         <= sec_rem_next;
      heartbeat_timer <= heartbeat_timer_next;
      telemetry_timer <= telemetry_timer_next;
      red_phase       <= red_phase_next;
      escalated       <= escalated_next;
      confirm_elapsed <= confirm_elapsed_next;
      poll_timer      <= poll_timer_next;
      drive_bits      <= drive_bits_next;
    end
  end

endmodule

// ===== design/door_open_alarm_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// door_open_alarm_sequencer_top
// Door-open alarm sequencer: one door sample per millisecond tick in, one
// indicator/buzzer/event result per tick out.
//
// Input channel: door_level with in_valid/in_stall; a beat moves at a clock
// edge with in_valid high and in_stall low. Output channel: the nine result
// fields with out_valid/out_stall, the same rule.
// Configuration: cfg_write, cfg_index, cfg_data write one register per edge;
// write only while no beat is in flight.
// Path: a sample accepted at an edge is taken into the input register,
// processed by the core into the result register and shown by out_valid.
// Throughput: one beat per cycle while out_stall is low; the state update is
// combinational counter logic between the input and result registers.
// When the receiver stalls, the result register holds; one more sample can
// wait in the input register, after which in_stall rises until the result
// is taken.
// Reset (rst, synchronous): both registers empty, registers at their reset
// values, door state closed with the core drives off (result_q is not reset).
// ----------------------------------------------------------------------------
module door_open_alarm_sequencer_top #(
  parameter int OPEN_TIME_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  door_level,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  red_on,
  output logic                                  green_on,
  output logic                                  buzzer_on,
  output logic                                  opened_flag,
  output logic                                  closed_flag,
  output logic                                  escalate_flag,
  output logic                                  heartbeat_flag,
  output logic                                  telemetry_flag,
  output logic [dalseq_pkg::SECS_OUT_BITS-1:0]  open_seconds,
  input  logic                                  cfg_write,
  input  logic [dalseq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [dalseq_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  dalseq_pkg::cfg_t    cfg;
  dalseq_pkg::result_t core_result;
  dalseq_pkg::result_t result_q;

  logic in_full;
  logic door_q;
  logic out_free;
  logic fire;
  logic in_take;

  // Handshake: result register free, input register advances into it
  assign out_free = !out_valid || !out_stall;
  assign fire     = in_full && out_free;
  assign in_stall = in_full && !out_free;
  assign in_take  = in_valid && !in_stall;

  dalseq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dalseq_core #(
    .OPEN_TIME_BITS (OPEN_TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (fire),
    .door   (door_q),
    .cfg    (cfg),
    .result (core_result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      door_q <= door_level;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_q <= core_result;
    end
  end

  assign red_on         = result_q.red_on;
  assign green_on       = result_q.green_on;
  assign buzzer_on      = result_q.buzzer_on;
  assign opened_flag    = result_q.opened_flag;
  assign closed_flag    = result_q.closed_flag;
  assign escalate_flag  = result_q.escalate_flag;
  assign heartbeat_flag = result_q.heartbeat_flag;
  assign telemetry_flag = result_q.telemetry_flag;
  assign open_seconds   = result_q.open_seconds;

endmodule
